// ===== rtl/tmhq_pkg.sv =====
`default_nettype none
package tmhq_pkg;
  localparam int CAPACITY    = 16;
  localparam int TIME_BITS   = 48;
  localparam int NUM_IDS     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ID_W        = 4;
  localparam int IVL_W       = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;

  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_REMOVED  = 3'd1;
  localparam logic [2:0] KIND_ABSENT   = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_DUP      = 3'd4;
  localparam logic [2:0] KIND_EXPIRED  = 3'd5;
  localparam logic [2:0] KIND_NONE     = 3'd6;

  typedef struct packed {
    logic [TIME_BITS-1:0] key;
    logic [ID_W-1:0]      id;
  } entry_t;
endpackage
`default_nettype wire

// ===== rtl/tmhq_if.sv =====
`default_nettype none
interface tmhq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  timer_id;
  logic [31:0] interval;
  logic        periodic;
  logic [47:0] now;
  modport source(output valid, action, timer_id, interval, periodic, now, input ready);
  modport sink(input valid, action, timer_id, interval, periodic, now, output ready);
endinterface

interface tmhq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  timer_id_res;
  logic [47:0] expiry_time;
  logic        last;
  modport source(output valid, kind, timer_id_res, expiry_time, last, input ready);
  modport sink(input valid, kind, timer_id_res, expiry_time, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tmhq_ram.sv =====
`default_nettype none
module tmhq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 52
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/timer_min_heap_queue_top.sv =====
// An add climbs the heap level by level, reading the parent and then comparing (S_UP_RD,
// S_UP_CMP); a remove climbs the same way or descends, reading the children and comparing
// (S_DN_RD, S_DN_C1, S_DN_C2). A check reads the top and compares it with now (S_CK_TOP,
// S_CK_CMP) for each expired timer, then removes it and, for a periodic timer, adds it again.
// One item at a time: the next is taken the cycle after its last result is loaded.
// Synchronous reset empties the heap and marks every timer absent; no clearing pass.
`default_nettype none
module timer_min_heap_queue_top (
  input  wire logic   clk,
  input  wire logic   rst,
  tmhq_in_if.sink     in_ch,
  tmhq_out_if.source  out_ch
);
  localparam int IW = tmhq_pkg::IDX_W;
  localparam int CW = tmhq_pkg::CNT_W;
  localparam int TB = tmhq_pkg::TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_C1, S_DN_C2, S_RM_LAST,
    S_CK_TOP, S_CK_CMP, S_CK_REINS, S_CK_END, S_EMIT
  } state_t;

  state_t state, ret;

  tmhq_pkg::entry_t cur, child_a, pend, res;
  logic [2:0]       res_kind;
  logic             have_pend;
  logic [IW-1:0]    at;
  logic [CW-1:0]    count;
  logic             up_first;
  logic [TB-1:0]    now;
  logic [tmhq_pkg::RES_W-1:0] n_done, budget;

  logic [IW-1:0]    pos [tmhq_pkg::NUM_IDS];
  logic [tmhq_pkg::NUM_IDS-1:0] present;
  logic [tmhq_pkg::IVL_W-1:0] ivls [tmhq_pkg::NUM_IDS];
  logic [tmhq_pkg::NUM_IDS-1:0] per_flags;

  logic             out_valid;
  logic             out_load;

  // memory port
  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  tmhq_pkg::entry_t ram_wdata, rdata;

  tmhq_ram #(.DEPTH(tmhq_pkg::CAPACITY), .WIDTH($bits(tmhq_pkg::entry_t))) u_heap (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(rdata)
  );

  logic [IW-1:0]    parent_idx;
  logic [IW:0]      c_idx;
  logic [IW+1:0]    c1_idx;
  logic             up_move;
  tmhq_pkg::entry_t dn_m;
  logic [IW-1:0]    dn_mi;
  logic             dn_stop;
  logic             out_free;
  logic             in_fire;
  logic [IW-1:0]    in_at;
  logic [IW-1:0]    last_idx;
  logic             due;
  logic [TB:0]      in_sum, re_sum;
  logic [TB-1:0]    in_key, re_key;

  assign parent_idx = (at - IW'(1)) >> 1;
  assign c_idx      = {at, 1'b1};
  assign c1_idx     = {1'b0, c_idx} + (IW+2)'(1);
  assign up_move    = cur.key < rdata.key;
  assign out_free   = !out_valid || out_ch.ready;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_at      = pos[in_ch.timer_id];
  assign last_idx   = IW'(count - CW'(1));
  assign due        = rdata.key <= now;
  assign out_load   = (state == S_CK_CMP && due && out_free && have_pend) ||
                      (state == S_EMIT && out_free);

  assign in_sum = {1'b0, in_ch.now[TB-1:0]} + (TB+1)'(in_ch.interval);
  assign in_key = in_sum[TB] ? '1 : in_sum[TB-1:0];
  assign re_sum = {1'b0, now} + (TB+1)'(ivls[pend.id]);
  assign re_key = re_sum[TB] ? '1 : re_sum[TB-1:0];

  always_comb begin
    if (state == S_DN_C2 && !(child_a.key < rdata.key)) begin
      dn_m  = rdata;
      dn_mi = IW'(c1_idx);
    end else if (state == S_DN_C2) begin
      dn_m  = child_a;
      dn_mi = IW'(c_idx);
    end else begin
      dn_m  = rdata;
      dn_mi = IW'(c_idx);
    end
  end
  assign dn_stop = cur.key < dn_m.key;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = at;
    ram_wdata = cur;
    ram_re    = 1'b0;
    ram_raddr = parent_idx;
    case (state)
      S_IDLE: begin
        ram_raddr = last_idx;
        ram_re = in_fire && in_ch.action == tmhq_pkg::ACT_REMOVE &&
                 present[in_ch.timer_id] && in_at != last_idx;
      end
      S_UP_RD: begin
        ram_we = (at == '0);
        ram_re = (at != '0);
      end
      S_UP_CMP: begin
        if (up_move) begin
          ram_we    = 1'b1;
          ram_wdata = rdata;
        end else begin
          ram_we = !up_first;
        end
      end
      S_DN_RD: begin
        ram_raddr = IW'(c_idx);
        ram_we    = ({1'b0, c_idx} >= (IW+2)'(count));
        ram_re    = !ram_we;
      end
      S_DN_C1: begin
        ram_raddr = IW'(c1_idx);
        if (c1_idx < (IW+2)'(count)) begin
          ram_re = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = dn_stop ? cur : dn_m;
        end
      end
      S_DN_C2: begin
        ram_we    = 1'b1;
        ram_wdata = dn_stop ? cur : dn_m;
      end
      S_RM_LAST: begin
        ram_re = (at != '0);
      end
      S_CK_TOP: begin
        ram_raddr = '0;
        ram_re = (n_done < budget) && (count != '0);
      end
      S_CK_CMP: begin
        ram_raddr = last_idx;
        ram_re = due && (out_free || !have_pend) && (last_idx != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      pos[ram_wdata.id] <= ram_waddr;
    end
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      count     <= '0;
      present   <= '0;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
      up_first  <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ch.ready);
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            now      <= in_ch.now[TB-1:0];
            res.id   <= in_ch.timer_id;
            up_first <= 1'b0;
            case (in_ch.action)
              tmhq_pkg::ACT_ADD: begin
                if (present[in_ch.timer_id]) begin
                  res_kind <= tmhq_pkg::KIND_DUP;
                  res.key  <= '0;
                  state    <= S_EMIT;
                end else if (count == CW'(tmhq_pkg::CAPACITY)) begin
                  res_kind <= tmhq_pkg::KIND_FULL;
                  res.key  <= '0;
                  state    <= S_EMIT;
                end else begin
                  res_kind                  <= tmhq_pkg::KIND_ADDED;
                  res.key                   <= in_key;
                  ivls[in_ch.timer_id]      <= in_ch.interval;
                  per_flags[in_ch.timer_id] <= in_ch.periodic;
                  present[in_ch.timer_id]   <= 1'b1;
                  cur   <= '{key: in_key, id: in_ch.timer_id};
                  at    <= IW'(count);
                  count <= count + CW'(1);
                  ret   <= S_EMIT;
                  state <= S_UP_RD;
                end
              end
              tmhq_pkg::ACT_REMOVE: begin
                res.key <= '0;
                if (!present[in_ch.timer_id]) begin
                  res_kind <= tmhq_pkg::KIND_ABSENT;
                  state    <= S_EMIT;
                end else begin
                  res_kind                <= tmhq_pkg::KIND_REMOVED;
                  present[in_ch.timer_id] <= 1'b0;
                  count <= count - CW'(1);
                  at    <= in_at;
                  ret   <= S_EMIT;
                  state <= (in_at != last_idx) ? S_RM_LAST : S_EMIT;
                end
              end
              tmhq_pkg::ACT_CHECK: begin
                n_done    <= '0;
                have_pend <= 1'b0;
                budget    <= (count < CW'(tmhq_pkg::MAX_RESULTS)) ?
                             tmhq_pkg::RES_W'(count) : tmhq_pkg::RES_W'(tmhq_pkg::MAX_RESULTS);
                state     <= S_CK_TOP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_UP_RD: begin
          state <= (at == '0) ? ret : S_UP_CMP;
        end
        S_UP_CMP: begin
          up_first <= 1'b0;
          if (up_move) begin
            at    <= parent_idx;
            state <= S_UP_RD;
          end else if (up_first) begin
            state <= S_DN_RD;
          end else begin
            state <= ret;
          end
        end
        S_DN_RD: begin
          state <= ram_we ? ret : S_DN_C1;
        end
        S_DN_C1: begin
          if (ram_re) begin
            child_a <= rdata;
            state   <= S_DN_C2;
          end else begin
            at    <= dn_mi;
            state <= dn_stop ? ret : S_DN_RD;
          end
        end
        S_DN_C2: begin
          at    <= dn_mi;
          state <= dn_stop ? ret : S_DN_RD;
        end
        S_RM_LAST: begin
          cur <= rdata;
          if (at != '0) begin
            up_first <= 1'b1;
            state    <= S_UP_CMP;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_CK_TOP: begin
          state <= ram_re ? S_CK_CMP : S_CK_END;
        end
        S_CK_CMP: begin
          if (!due) begin
            state <= S_CK_END;
          end else if (out_free || !have_pend) begin
            if (have_pend) begin
              out_ch.kind         <= tmhq_pkg::KIND_EXPIRED;
              out_ch.timer_id_res <= pend.id;
              out_ch.expiry_time  <= pend.key;
              out_ch.last         <= 1'b0;
            end
            pend             <= rdata;
            have_pend        <= 1'b1;
            n_done           <= n_done + tmhq_pkg::RES_W'(1);
            present[rdata.id] <= 1'b0;
            count            <= count - CW'(1);
            at               <= '0;
            ret              <= S_CK_REINS;
            state            <= (last_idx != '0) ? S_RM_LAST : S_CK_REINS;
          end
        end
        S_CK_REINS: begin
          if (per_flags[pend.id]) begin
            present[pend.id] <= 1'b1;
            cur   <= '{key: re_key, id: pend.id};
            at    <= IW'(count);
            count <= count + CW'(1);
            ret   <= S_CK_TOP;
            state <= S_UP_RD;
          end else begin
            state <= S_CK_TOP;
          end
        end
        S_CK_END: begin
          if (have_pend) begin
            res_kind <= tmhq_pkg::KIND_EXPIRED;
            res      <= pend;
          end else begin
            res_kind <= tmhq_pkg::KIND_NONE;
            res      <= '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.kind         <= res_kind;
            out_ch.timer_id_res <= res.id;
            out_ch.expiry_time  <= res.key;
            out_ch.last         <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE) && !rst;
  assign out_ch.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(tmhq_pkg::CAPACITY)) else $error("heap count above capacity");
  a_present_count: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == 32'(count)) else $error("present bits disagree with count");
  a_up_nonroot: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> at != '0) else $error("parent compare at root");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> state == S_IDLE && out_valid)
    else $error("final result not presented");
endmodule
`default_nettype wire

// ===== tb/timer_min_heap_queue_checker.sv =====
`default_nettype none
module timer_min_heap_queue_checker (
  input  wire logic clk,
  input  wire logic rst,
  tmhq_in_if.sink   in_mon,
  tmhq_out_if.sink  out_mon,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB  = tmhq_pkg::TIME_BITS;
  localparam int IDW = tmhq_pkg::ID_W;
  localparam int IVW = tmhq_pkg::IVL_W;

  typedef struct packed {
    logic [2:0]     kind;
    logic [IDW-1:0] id;
    logic [TB-1:0]  expiry;
    logic           last;
  } timer_result_t;

  logic [TB-1:0]  keys [tmhq_pkg::CAPACITY];
  logic [IDW-1:0] ids [tmhq_pkg::CAPACITY];
  int             slot_of [tmhq_pkg::NUM_IDS];
  bit             active [tmhq_pkg::NUM_IDS];
  logic [IVW-1:0] period_ms [tmhq_pkg::NUM_IDS];
  bit             reload [tmhq_pkg::NUM_IDS];
  int             count;
  timer_result_t  expected_q[$];

  localparam logic [TB-1:0] TMAX = '1;

  assign pending = expected_q.size();

  function automatic logic [TB-1:0] expiry_at(logic [TB-1:0] t, logic [IVW-1:0] d);
    logic [TB:0] s;
    s = {1'b0, t} + (TB+1)'(d);
    return s[TB] ? TMAX : s[TB-1:0];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [TB-1:0]  k;
    logic [IDW-1:0] i;
    k = keys[a]; i = ids[a];
    keys[a] = keys[b]; ids[a] = ids[b];
    keys[b] = k; ids[b] = i;
    slot_of[ids[a]] = a;
    slot_of[ids[b]] = b;
  endfunction

  function automatic void bubble_up(int at);
    int up;
    while (at > 0) begin
      up = (at - 1) / 2;
      if (!(keys[at] < keys[up])) break;
      swap_entries(at, up);
      at = up;
    end
  endfunction

  function automatic void bubble_down(int at);
    int c;
    int m;
    c = at * 2 + 1;
    while (c < count) begin
      m = (c + 1 == count || keys[c] < keys[c + 1]) ? c : c + 1;
      if (keys[at] < keys[m]) break;
      swap_entries(at, m);
      at = m;
      c = at * 2 + 1;
    end
  endfunction

  function automatic void push_timer(logic [IDW-1:0] id, logic [TB-1:0] key);
    keys[count] = key;
    ids[count] = id;
    slot_of[id] = count;
    active[id] = 1;
    count++;
    bubble_up(count - 1);
  endfunction

  function automatic void drop_timer(logic [IDW-1:0] id);
    int at;
    int tail;
    at = slot_of[id];
    tail = count - 1;
    active[id] = 0;
    if (at >= count) return;
    if (at != tail) swap_entries(at, tail);
    count = tail;
    if (at < tail) begin
      if (at > 0 && keys[at] < keys[(at - 1) / 2]) bubble_up(at);
      else bubble_down(at);
    end
  endfunction

  function automatic void queue_result(logic [2:0] k, logic [IDW-1:0] id,
                                       logic [TB-1:0] t, logic l);
    timer_result_t r;
    r.kind = k; r.id = id; r.expiry = t; r.last = l;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void apply_request(logic [1:0] act, logic [IDW-1:0] id,
                                        logic [IVW-1:0] ivl, logic per,
                                        logic [TB-1:0] now);
    logic [TB-1:0]  key;
    logic [IDW-1:0] top;
    int             budget;
    int             n;
    case (act)
      tmhq_pkg::ACT_ADD: begin
        if (active[id]) queue_result(tmhq_pkg::KIND_DUP, id, '0, 1'b1);
        else if (count >= tmhq_pkg::CAPACITY) queue_result(tmhq_pkg::KIND_FULL, id, '0, 1'b1);
        else begin
          period_ms[id] = ivl;
          reload[id] = per;
          key = expiry_at(now, ivl);
          push_timer(id, key);
          queue_result(tmhq_pkg::KIND_ADDED, id, key, 1'b1);
        end
      end
      tmhq_pkg::ACT_REMOVE: begin
        if (!active[id]) queue_result(tmhq_pkg::KIND_ABSENT, id, '0, 1'b1);
        else begin
          drop_timer(id);
          queue_result(tmhq_pkg::KIND_REMOVED, id, '0, 1'b1);
        end
      end
      tmhq_pkg::ACT_CHECK: begin
        budget = count < tmhq_pkg::MAX_RESULTS ? count : tmhq_pkg::MAX_RESULTS;
        n = 0;
        while (n < budget && count > 0 && keys[0] <= now) begin
          top = ids[0];
          key = keys[0];
          drop_timer(top);
          if (reload[top]) push_timer(top, expiry_at(now, period_ms[top]));
          queue_result(tmhq_pkg::KIND_EXPIRED, top, key, 1'b0);
          n++;
        end
        if (n == 0) queue_result(tmhq_pkg::KIND_NONE, '0, '0, 1'b1);
        else expected_q[expected_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  timer_result_t got;
  timer_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      count = 0;
      fail_count <= 0;
      for (int i = 0; i < tmhq_pkg::NUM_IDS; i++) active[i] = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.action, in_mon.timer_id, in_mon.interval, in_mon.periodic,
                      in_mon.now);
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.kind, out_mon.timer_id_res, out_mon.expiry_time, out_mon.last};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/timer_min_heap_queue_top_test.sv =====
`default_nettype none
module timer_min_heap_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG    = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int TB          = tmhq_pkg::TIME_BITS;
  localparam int IDW         = tmhq_pkg::ID_W;
  localparam int IVW         = tmhq_pkg::IVL_W;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  int   hold_cnt;
  int   quiet_cycles;
  bit   timed_out;
  logic [TB-1:0] clock_ms;

  tmhq_in_if  in_ch();
  tmhq_out_if out_ch();

  timer_min_heap_queue_top i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  timer_min_heap_queue_checker i_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] act, logic [IDW-1:0] id,
                              logic [IVW-1:0] ivl, logic per, logic [TB-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.timer_id <= id;
    in_ch.interval <= ivl;
    in_ch.periodic <= per;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int r;
    logic [IVW-1:0] ivl;
    r = $urandom_range(99);
    clock_ms = clock_ms + TB'($urandom_range(60));
    if ($urandom_range(49) == 0) clock_ms = TB'({$urandom, $urandom});
    ivl = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200, 1);
    if (ivl == 0) ivl = 1;
    if (r < 45)
      send_request(tmhq_pkg::ACT_ADD, IDW'($urandom_range(15)), ivl,
                   1'($urandom_range(1)), clock_ms);
    else if (r < 65)
      send_request(tmhq_pkg::ACT_REMOVE, IDW'($urandom_range(15)), ivl,
                   1'($urandom_range(1)), clock_ms);
    else if (r < 97)
      send_request(tmhq_pkg::ACT_CHECK, IDW'($urandom_range(15)), $urandom,
                   1'($urandom_range(1)), clock_ms);
    else
      send_request(ACT_UNUSED, IDW'($urandom_range(15)), $urandom,
                   1'($urandom_range(1)), TB'({$urandom, $urandom}));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = tmhq_pkg::ACT_ADD;
    in_ch.timer_id = '0;
    in_ch.interval = 32'd1;
    in_ch.periodic = 1'b0;
    in_ch.now = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    clock_ms = TB'(1000);
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every action, the special cases
    send_request(tmhq_pkg::ACT_CHECK, 4'd0, 32'd1, 1'b0, '0);        // nothing due
    send_request(tmhq_pkg::ACT_REMOVE, 4'd7, 32'd1, 1'b0, '0);       // absent remove
    send_request(tmhq_pkg::ACT_ADD, 4'd0, 32'd1, 1'b0, '0);
    send_request(tmhq_pkg::ACT_ADD, 4'd15, 32'hFFFF_FFFF, 1'b1, '1); // saturates
    send_request(tmhq_pkg::ACT_ADD, 4'd0, 32'd5, 1'b1, 48'd10);      // duplicate
    send_request(ACT_UNUSED, 4'd9, 32'd3, 1'b1, '1);                 // ignored
    for (int i = 1; i < 15; i++)
      send_request(tmhq_pkg::ACT_ADD, i[3:0], (i % 3 == 0) ? 32'd7 : i, i[0], 48'd100);
    send_request(tmhq_pkg::ACT_ADD, 4'd15, 32'd3, 1'b0, 48'd0);      // duplicate while full
    send_request(tmhq_pkg::ACT_REMOVE, 4'd5, 32'd1, 1'b0, 48'd0);
    send_request(tmhq_pkg::ACT_ADD, 4'd5, 32'd2, 1'b0, 48'h5555_5555_5555);
    send_request(tmhq_pkg::ACT_CHECK, 4'd0, 32'd1, 1'b0, '1);        // pop everything once
    send_request(tmhq_pkg::ACT_CHECK, 4'd0, 32'd1, 1'b0, '1);        // saturated reloads due

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (phase == 2) hold_req = 1;
      for (int n = 0; n < 34; n++) random_request();
      if (phase == 3)
        for (int n = 0; n < 10; n++) random_request();
    end
    idle_input();
    send_idle_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/tmhq_pkg.sv
rtl/tmhq_if.sv
rtl/tmhq_ram.sv
rtl/timer_min_heap_queue_top.sv
tb/timer_min_heap_queue_checker.sv
tb/timer_min_heap_queue_top_test.sv
